// ===== hw/rtl/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, constants and the sine table generator for the vertex
// rotate/project pipeline.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int IN_W    = 16;  // Q8.8 vertex coordinate
  localparam int COORD_W = 18;  // rotated coordinate, full range
  localparam int TRIG_W  = 16;  // signed Q1.14 sin/cos
  localparam int PROD_W  = COORD_W + TRIG_W;
  localparam int SCR_W   = 13;
  localparam int ANG_W   = 10;
  localparam int CAM_W   = 15;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int OFS_W   = COORD_W + 1;   // coordinate after offset
  localparam int DEP_W   = COORD_W + 2;   // z + shift + camera distance
  localparam int D_W     = DEP_W - 1;     // positive depth, unsigned
  localparam int Q_BITS  = 12;            // quotient bits below saturation
  localparam int DIV_ST  = Q_BITS + 2;    // prep, one stage per bit, output
  localparam int ROT_ST  = 2;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TAYLOR_DIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  localparam logic signed [SCR_W-1:0] SCREEN_MAX = 13'sd4095;
  localparam logic signed [SCR_W-1:0] SCREEN_MIN = -13'sd4096;
  localparam logic [CAM_W-1:0] CAM_RESET = 15'd2560;

  typedef enum logic [IDX_W-1:0] {
    REG_ANGLE_X = 3'd0,
    REG_ANGLE_Y = 3'd1,
    REG_ANGLE_Z = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5,
    REG_CAM     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_x;
    logic signed [TRIG_W-1:0] cos_x;
    logic signed [TRIG_W-1:0] sin_y;
    logic signed [TRIG_W-1:0] cos_y;
    logic signed [TRIG_W-1:0] sin_z;
    logic signed [TRIG_W-1:0] cos_z;
    logic signed [IN_W-1:0]   shift_x;
    logic signed [IN_W-1:0]   shift_y;
    logic signed [IN_W-1:0]   shift_z;
    logic [CAM_W-1:0]         cam;
  } cfg_t;

  // Q30 Taylor series of sin, rounded to Q14 and capped at 1.0
  function automatic logic [14:0] sine_q14(input longint x);
    longint t;
    longint s;
    longint v;
    t = x;
    s = x;
    for (int k = 1; k <= 8; k++) begin
      t = (t * x) >>> 30;
      t = ((t * x) >>> 30) / TAYLOR_DIV[k];
      if (k[0]) s = s - t;
      else s = s + t;
    end
    if (s < 0) s = 0;
    v = (s + 64'sd32768) >>> 16;
    if (v > 16384) v = 16384;
    return v[14:0];
  endfunction

endpackage

// ===== hw/rtl/vrp_cfg.sv =====
// ----------------------------------------------------------------------------
// vrp_cfg
// Configuration registers and registered sin/cos lookup of the three angles.
// ----------------------------------------------------------------------------
module vrp_cfg import vrp_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  logic [14:0] rom_a [256];
  logic [14:0] rom_b [256];

  for (genvar g = 0; g < 256; g++) begin : g_rom
    localparam longint IA = (longint'(g) * SINE_TABLE_DEPTH) / 256;
    localparam longint IB = SINE_TABLE_DEPTH - IA;
    localparam longint XA = (IA * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    localparam longint XB = (IB * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    assign rom_a[g] = sine_q14(XA);
    assign rom_b[g] = sine_q14(XB);
  end

  logic [ANG_W-1:0] ang_x_r, ang_y_r, ang_z_r;
  logic signed [IN_W-1:0] shx_r, shy_r, shz_r;
  logic [CAM_W-1:0] cam_r;
  logic signed [TRIG_W-1:0] sx_r, cx_r, sy_r, cy_r, sz_r, cz_r;

  function automatic logic signed [TRIG_W-1:0] trig(input logic [ANG_W-1:0] a);
    logic [14:0] mag;
    mag = a[8] ? rom_b[a[7:0]] : rom_a[a[7:0]];
    return a[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_x_r <= '0;
      ang_y_r <= '0;
      ang_z_r <= '0;
      shx_r   <= '0;
      shy_r   <= '0;
      shz_r   <= '0;
      cam_r   <= CAM_RESET;
      sx_r    <= '0;
      sy_r    <= '0;
      sz_r    <= '0;
      cx_r    <= 16'sd16384;
      cy_r    <= 16'sd16384;
      cz_r    <= 16'sd16384;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ANGLE_X: ang_x_r <= cfg_wdata[ANG_W-1:0];
          REG_ANGLE_Y: ang_y_r <= cfg_wdata[ANG_W-1:0];
          REG_ANGLE_Z: ang_z_r <= cfg_wdata[ANG_W-1:0];
          REG_SHIFT_X: shx_r   <= cfg_wdata;
          REG_SHIFT_Y: shy_r   <= cfg_wdata;
          REG_SHIFT_Z: shz_r   <= cfg_wdata;
          REG_CAM:     cam_r   <= cfg_wdata[CAM_W-1:0];
          default: ;
        endcase
      end
      sx_r <= trig(ang_x_r);
      cx_r <= trig(ang_x_r + 10'd256);
      sy_r <= trig(ang_y_r);
      cy_r <= trig(ang_y_r + 10'd256);
      sz_r <= trig(ang_z_r);
      cz_r <= trig(ang_z_r + 10'd256);
    end
  end

  assign cfg = '{sin_x: sx_r, cos_x: cx_r, sin_y: sy_r, cos_y: cy_r,
                 sin_z: sz_r, cos_z: cz_r, shift_x: shx_r, shift_y: shy_r,
                 shift_z: shz_r, cam: cam_r};

endmodule

// ===== hw/rtl/vrp_rot.sv =====
// ----------------------------------------------------------------------------
// vrp_rot
// One plane rotation, two stages: products, then sum and Q14 rounding.
// p' = p*c - q*s, q' = p*s + q*c; a third coordinate rides along.
// ----------------------------------------------------------------------------
module vrp_rot import vrp_pkg::*; (
  input  logic                      clk,
  input  logic [ROT_ST-1:0]         en,
  input  logic signed [COORD_W-1:0] p,
  input  logic signed [COORD_W-1:0] q,
  input  logic signed [COORD_W-1:0] carry,
  input  logic signed [TRIG_W-1:0]  s,
  input  logic signed [TRIG_W-1:0]  c,
  output logic signed [COORD_W-1:0] p_out,
  output logic signed [COORD_W-1:0] q_out,
  output logic signed [COORD_W-1:0] carry_out
);

  logic signed [PROD_W-1:0] pc_r, qs_r, ps_r, qc_r;
  logic signed [COORD_W-1:0] carry_r, p_r, q_r, carry2_r;
  logic signed [PROD_W:0] sum_p, sum_q;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pc_r    <= PROD_W'(p * c);
      qs_r    <= PROD_W'(q * s);
      ps_r    <= PROD_W'(p * s);
      qc_r    <= PROD_W'(q * c);
      carry_r <= carry;
    end
  end

  assign sum_p = (PROD_W+1)'(pc_r) - (PROD_W+1)'(qs_r) + (PROD_W+1)'(8192);
  assign sum_q = (PROD_W+1)'(ps_r) + (PROD_W+1)'(qc_r) + (PROD_W+1)'(8192);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_r      <= sum_p[14 +: COORD_W];
      q_r      <= sum_q[14 +: COORD_W];
      carry2_r <= carry_r;
    end
  end

  assign p_out     = p_r;
  assign q_out     = q_r;
  assign carry_out = carry2_r;

endmodule

// ===== hw/rtl/vrp_div.sv =====
// ----------------------------------------------------------------------------
// vrp_div
// Two-lane pipelined restoring divider, one quotient bit per stage, with
// truncation toward zero, saturation and the behind-camera case.
// ----------------------------------------------------------------------------
module vrp_div import vrp_pkg::*; #(
  parameter int NUM_W = 26
) (
  input  logic                    clk,
  input  logic [DIV_ST-1:0]       en,
  input  logic signed [NUM_W-1:0] num [2],
  input  logic [D_W-1:0]          den,
  input  logic                    behind,
  output logic signed [SCR_W-1:0] scr [2],
  output logic                    behind_out
);

  localparam int W = (NUM_W > D_W + Q_BITS) ? NUM_W + 1 : D_W + Q_BITS + 1;

  logic [W-1:0]      rem_r  [Q_BITS+1][2];
  logic [Q_BITS-1:0] quo_r  [Q_BITS+1][2];
  logic [1:0]        neg_r  [Q_BITS+1];
  logic [1:0]        ovf_r  [Q_BITS+1];
  logic [D_W-1:0]    d_r    [Q_BITS+1];
  logic              beh_r  [Q_BITS+1];
  logic signed [SCR_W-1:0] scr_r [2];
  logic              beh_out_r;

  logic [NUM_W-1:0] mag [2];
  logic [W-1:0]     lim;

  assign lim = W'(den) << Q_BITS;

  for (genvar l = 0; l < 2; l++) begin : g_abs
    assign mag[l] = num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[0][l] <= W'(mag[l]);
        quo_r[0][l] <= '0;
        neg_r[0][l] <= num[l][NUM_W-1];
        ovf_r[0][l] <= W'(mag[l]) >= lim;
      end
      d_r[0]   <= den;
      beh_r[0] <= behind;
    end
  end

  for (genvar k = 1; k <= Q_BITS; k++) begin : g_step
    logic [W-1:0] sub [2];
    for (genvar l = 0; l < 2; l++) begin : g_lane
      assign sub[l] = rem_r[k-1][l] - (W'(d_r[k-1]) << (Q_BITS - k));
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        for (int l = 0; l < 2; l++) begin
          quo_r[k][l] <= quo_r[k-1][l];
          if (!sub[l][W-1]) begin
            rem_r[k][l] <= sub[l];
            quo_r[k][l][Q_BITS-k] <= 1'b1;
          end else begin
            rem_r[k][l] <= rem_r[k-1][l];
          end
        end
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        d_r[k]   <= d_r[k-1];
        beh_r[k] <= beh_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[DIV_ST-1]) begin
      for (int l = 0; l < 2; l++) begin
        if (beh_r[Q_BITS]) scr_r[l] <= '0;
        else if (ovf_r[Q_BITS][l]) scr_r[l] <= neg_r[Q_BITS][l] ? SCREEN_MIN : SCREEN_MAX;
        else if (neg_r[Q_BITS][l]) scr_r[l] <= -$signed({1'b0, quo_r[Q_BITS][l]});
        else scr_r[l] <= $signed({1'b0, quo_r[Q_BITS][l]});
      end
      beh_out_r <= beh_r[Q_BITS];
    end
  end

  assign scr        = scr_r;
  assign behind_out = beh_out_r;

endmodule

// ===== hw/rtl/vertex_rotate_project.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project
// Rotates a Q8.8 vertex about X, Y and Z, offsets it and projects it to a
// saturated 13-bit screen position.
// Stages: three rotations of two stages, offset, scale multiply, and a 12-bit
//   restoring divider plus prep/output, from input word to output word.
// Throughput: one word per cycle; each stage holds under back-pressure.
// Reset: synchronous; clears valid bits and restores register defaults.
// ----------------------------------------------------------------------------
module vertex_rotate_project import vrp_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PROJECTION_SCALE = 35
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  in_point_x,
  input  logic signed [IN_W-1:0]  in_point_y,
  input  logic signed [IN_W-1:0]  in_point_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SCR_W-1:0] out_screen_x,
  output logic signed [SCR_W-1:0] out_screen_y,
  output logic                    out_behind_camera
);

  localparam int SCALE_W = $clog2(PROJECTION_SCALE + 1);
  localparam int NUM_W   = OFS_W + SCALE_W + 1;
  localparam int N       = 3 * ROT_ST + 2 + DIV_ST;
  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(PROJECTION_SCALE);

  cfg_t cfg;
  logic [N-1:0] v_r;
  logic [N-1:0] en;

  vrp_cfg #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .cfg
  );

  // stall chain: a stage loads when empty or when the next one loads
  always_comb begin
    en[N-1] = !v_r[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];

  logic signed [COORD_W-1:0] x0, y0, z0, y1, z1, x1, z2, x2, y2, x3, y3, z3;

  assign x0 = COORD_W'(in_point_x);
  assign y0 = COORD_W'(in_point_y);
  assign z0 = COORD_W'(in_point_z);

  vrp_rot u_rot_x (
    .clk, .en(en[1:0]), .p(y0), .q(z0), .carry(x0), .s(cfg.sin_x), .c(cfg.cos_x),
    .p_out(y1), .q_out(z1), .carry_out(x1)
  );

  vrp_rot u_rot_y (
    .clk, .en(en[3:2]), .p(z1), .q(x1), .carry(y1), .s(cfg.sin_y), .c(cfg.cos_y),
    .p_out(z2), .q_out(x2), .carry_out(y2)
  );

  vrp_rot u_rot_z (
    .clk, .en(en[5:4]), .p(x2), .q(y2), .carry(z2), .s(cfg.sin_z), .c(cfg.cos_z),
    .p_out(x3), .q_out(y3), .carry_out(z3)
  );

  // offset and depth
  logic signed [OFS_W-1:0] xo_r, yo_r;
  logic signed [DEP_W-1:0] dep, dep_r;
  logic                    beh_o_r;

  assign dep = DEP_W'(z3) + DEP_W'(cfg.shift_z) + DEP_W'({1'b0, cfg.cam});

  always_ff @(posedge clk) begin
    if (en[6]) begin
      xo_r    <= OFS_W'(x3) + OFS_W'(cfg.shift_x);
      yo_r    <= OFS_W'(y3) - OFS_W'(cfg.shift_y);
      dep_r   <= dep;
      beh_o_r <= dep[DEP_W-1] || (dep == '0);
    end
  end

  // scale multiply
  logic signed [NUM_W-1:0] num_r [2];
  logic [D_W-1:0]          den_r;
  logic                    beh_m_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      num_r[0] <= NUM_W'(xo_r * $signed({1'b0, SCALE}));
      num_r[1] <= NUM_W'(yo_r * $signed({1'b0, SCALE}));
      den_r    <= dep_r[D_W-1:0];
      beh_m_r  <= beh_o_r;
    end
  end

  logic signed [SCR_W-1:0] scr [2];

  vrp_div #(.NUM_W(NUM_W)) u_div (
    .clk, .en(en[N-1:8]), .num(num_r), .den(den_r), .behind(beh_m_r),
    .scr, .behind_out(out_behind_camera)
  );

  assign out_screen_x = scr[0];
  assign out_screen_y = scr[1];

  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_behind_camera |-> out_screen_x == '0 && out_screen_y == '0)
    else $error("behind-camera word with nonzero coordinates");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && v_r == {N{1'b1}})
    else $error("input stalled with a bubble in the pipeline");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted word missing from first stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== tb/tb_vertex_rotate_project.sv =====
// ----------------------------------------------------------------------------
// tb_vertex_rotate_project
// Streams vertex words through the rotate/project pipeline. The expected
// screen words are computed alongside with a fixed-point model. Register
// settings change between phases once the pipeline has drained. Both sides
// idle and stall at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_vertex_rotate_project;
  import vrp_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [IN_W-1:0] px;
    logic signed [IN_W-1:0] py;
    logic signed [IN_W-1:0] pz;
  } vertex_t;

  typedef struct {
    logic signed [SCR_W-1:0] sx;
    logic signed [SCR_W-1:0] sy;
    logic                    behind;
  } screen_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IN_W-1:0] in_point_x = '0;
  logic signed [IN_W-1:0] in_point_y = '0;
  logic signed [IN_W-1:0] in_point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SCR_W-1:0] out_screen_x;
  logic signed [SCR_W-1:0] out_screen_y;
  logic out_behind_camera;

  vertex_t vertex_q[$];
  screen_t screen_q[$];
  longint sine_tab[0:256];
  logic [ANG_W-1:0] ang_x, ang_y, ang_z;
  longint ofs_x, ofs_y, ofs_z, cam_dist;
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int behind_seen = 0;
  int clipped_seen = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  bit no_idle = 0;

  vertex_rotate_project dut (.*);

  always #10 clk = ~clk;

  function automatic void build_sine();
    longint x, t, s, v;
    for (int i = 0; i <= 256; i++) begin
      x = (longint'(i) * HALF_PI_Q30) / 256;
      t = x;
      s = x;
      for (int k = 1; k <= 8; k++) begin
        t = (t * x) >>> 30;
        t = ((t * x) >>> 30) / ((2 * k) * (2 * k + 1));
        s = k[0] ? s - t : s + t;
      end
      if (s < 0) s = 0;
      v = (s + 32768) >>> 16;
      sine_tab[i] = (v > 16384) ? 16384 : v;
    end
  endfunction

  function automatic longint sin_lookup(logic [ANG_W-1:0] a);
    longint m;
    m = a[8] ? sine_tab[256 - a[7:0]] : sine_tab[a[7:0]];
    return a[9] ? -m : m;
  endfunction

  function automatic longint rnd14(longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic longint sat_screen(longint v);
    if (v > 4095) return 4095;
    if (v < -4096) return -4096;
    return v;
  endfunction

  function automatic screen_t project_vertex(vertex_t p);
    longint x, y, z, s, c, nx, ny, nz, d;
    screen_t r;
    x = p.px;
    y = p.py;
    z = p.pz;
    s = sin_lookup(ang_x);
    c = sin_lookup(ang_x + 10'd256);
    ny = rnd14(y * c - z * s);
    nz = rnd14(y * s + z * c);
    y = ny;
    z = nz;
    s = sin_lookup(ang_y);
    c = sin_lookup(ang_y + 10'd256);
    nx = rnd14(x * c + z * s);
    nz = rnd14(z * c - x * s);
    x = nx;
    z = nz;
    s = sin_lookup(ang_z);
    c = sin_lookup(ang_z + 10'd256);
    nx = rnd14(x * c - y * s);
    ny = rnd14(x * s + y * c);
    x = nx + ofs_x;
    y = ny - ofs_y;
    z = z + ofs_z;
    d = z + cam_dist;
    if (d <= 0) begin
      r.sx = '0;
      r.sy = '0;
      r.behind = 1'b1;
    end else begin
      r.sx = SCR_W'(sat_screen((x * 35) / d));
      r.sy = SCR_W'(sat_screen((y * 35) / d));
      r.behind = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    vertex_t v;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        v.px = in_point_x;
        v.py = in_point_y;
        v.pz = in_point_z;
        screen_q = {screen_q, project_vertex(v)};
        words_in++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (vertex_q.size() > 0) begin
          v = vertex_q.pop_front();
          in_point_x <= v.px;
          in_point_y <= v.py;
          in_point_z <= v.pz;
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    screen_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_out++;
        if (screen_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word x=%0d y=%0d behind=%0b", $time,
                   out_screen_x, out_screen_y, out_behind_camera);
        end else begin
          e = screen_q.pop_front();
          if (e.behind) behind_seen++;
          if (e.sx == 4095 || e.sx == -4096 || e.sy == 4095 || e.sy == -4096)
            clipped_seen++;
          if (out_screen_x !== e.sx) begin
            errors++;
            $display("%0t: screen_x expected %0d actual %0d", $time, e.sx, out_screen_x);
          end
          if (out_screen_y !== e.sy) begin
            errors++;
            $display("%0t: screen_y expected %0d actual %0d", $time, e.sy, out_screen_y);
          end
          if (out_behind_camera !== e.behind) begin
            errors++;
            $display("%0t: behind_camera expected %0b actual %0b", $time, e.behind,
                     out_behind_camera);
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (vertex_q.size() == 0 && screen_q.size() == 0 && !in_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d words outstanding", $time, screen_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic reg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ANGLE_X: ang_x = val[ANG_W-1:0];
      REG_ANGLE_Y: ang_y = val[ANG_W-1:0];
      REG_ANGLE_Z: ang_z = val[ANG_W-1:0];
      REG_SHIFT_X: ofs_x = $signed(val);
      REG_SHIFT_Y: ofs_y = $signed(val);
      REG_SHIFT_Z: ofs_z = $signed(val);
      REG_CAM:     cam_dist = val[CAM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (vertex_q.size() > 0 || in_valid || screen_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_vertex(int x, int y, int z);
    vertex_t v;
    v.px = IN_W'(x);
    v.py = IN_W'(y);
    v.pz = IN_W'(z);
    vertex_q = {vertex_q, v};
  endtask

  function automatic int rnd_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return int'($urandom_range(0, 4095)) - 2048;
    if (r < 8) return int'($urandom_range(0, 65535)) - 32768;
    if (r < 9) return 32767;
    return -32768;
  endfunction

  task automatic random_settings();
    reg_write(REG_ANGLE_X, CFG_W'($urandom));
    reg_write(REG_ANGLE_Y, CFG_W'($urandom));
    reg_write(REG_ANGLE_Z, CFG_W'($urandom));
    reg_write(REG_SHIFT_X, CFG_W'($urandom_range(0, 3) == 0 ? $urandom :
                                  $urandom_range(0, 2047) - 1024));
    reg_write(REG_SHIFT_Y, CFG_W'($urandom_range(0, 3) == 0 ? $urandom :
                                  $urandom_range(0, 2047) - 1024));
    reg_write(REG_SHIFT_Z, CFG_W'($urandom_range(0, 3) == 0 ? $urandom :
                                  $urandom_range(0, 2047) - 1024));
    reg_write(REG_CAM, CFG_W'($urandom_range(0, 3) == 0 ? $urandom :
                              $urandom_range(256, 8191)));
  endtask

  initial begin
    build_sine();
    ang_x = '0;
    ang_y = '0;
    ang_z = '0;
    ofs_x = 0;
    ofs_y = 0;
    ofs_z = 0;
    cam_dist = 2560;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // reset settings: extremes and behind-camera points
    no_idle = 1;
    add_vertex(0, 0, 0);
    add_vertex(32767, 32767, 32767);
    add_vertex(-32768, -32768, -32768);
    add_vertex(256, -256, 0);
    add_vertex(32767, -32768, -2560);
    add_vertex(100, 100, -2561);
    add_vertex(-32768, 32767, -2559);
    add_vertex(512, 512, 512);
    drain();

    // extreme settings, zero camera distance, spare bits, unused index
    no_idle = 0;
    reg_write(REG_ANGLE_X, 16'hFFFF);
    reg_write(REG_ANGLE_Y, 16'd256);
    reg_write(REG_ANGLE_Z, 16'd512);
    reg_write(REG_SHIFT_X, 16'h7FFF);
    reg_write(REG_SHIFT_Y, 16'h8000);
    reg_write(REG_SHIFT_Z, 16'h7FFF);
    reg_write(REG_CAM, 16'h0000);
    reg_write(REG_UNUSED, 16'h1234);
    add_vertex(0, 0, 0);
    add_vertex(32767, 32767, 32767);
    add_vertex(-32768, -32768, -32768);
    add_vertex(1000, -1000, 0);
    add_vertex(0, 0, -32768);
    drain();
    reg_write(REG_CAM, 16'hFFFF);
    reg_write(REG_SHIFT_Z, 16'h8000);
    reg_write(REG_ANGLE_X, 16'd768);
    add_vertex(0, 0, 0);
    add_vertex(32767, -32768, 32767);
    add_vertex(-32768, 32767, 0);
    add_vertex(300, 300, 32767);
    drain();
    reg_write(REG_CAM, 16'd1);
    reg_write(REG_SHIFT_X, 16'd0);
    reg_write(REG_SHIFT_Y, 16'd0);
    reg_write(REG_SHIFT_Z, 16'd0);
    add_vertex(256, 256, 0);
    add_vertex(-256, -256, 0);
    add_vertex(0, 0, 32767);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_settings();
      no_idle = (ph % 3 == 1);
      for (int i = 0; i < 200; i++) add_vertex(rnd_coord(), rnd_coord(), rnd_coord());
      if (ph == 2) begin
        repeat (5) @(posedge clk);
        hold_req++;
      end
      drain();
    end

    $display("%0d vertex words in, %0d screen words out over 12 register settings",
             words_in, words_out);
    $display("%0d behind the camera, %0d saturated", behind_seen, clipped_seen);
    if (errors == 0 && screen_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
